>>> hdl/ghdc_pkg.sv
// ----------------------------------------------------------------------------
// Gyro heading drift compensator: shared package
// Types, fixed-point constants and small helpers used by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package ghdc_pkg;

    // Shared divider geometry: the widest dividend is the filter product.
    localparam int DVD_W     = 76;
    localparam int DVS_W     = 64;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // pi/180 with LSB 2^-32.
    localparam logic signed [27:0] DEG2RAD_Q32 = 28'sd74961321;

    // pi and 2*pi with LSB 2^-32, in the heading adder's width.
    localparam logic signed [46:0] PI_Q     = 47'sd13493037705;
    localparam logic signed [46:0] TWO_PI_Q = 47'sd26986075409;
    localparam logic signed [46:0] S36_MAX  = 47'sd34359738367;
    localparam logic signed [46:0] S36_MIN  = -47'sd34359738368;

    localparam logic signed [50:0] S51_MAX = {1'b0, {50{1'b1}}};
    localparam logic signed [50:0] S51_MIN = {1'b1, {50{1'b0}}};

    localparam logic signed [65:0] S64_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] S64_MIN = -66'sh0_8000_0000_0000_0000;

    // One in Q24.
    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CAL_SAMPLES   = 3'd0;
    localparam logic [2:0] REG_FILTER_TAU    = 3'd1;
    localparam logic [2:0] REG_ATTEN_C1      = 3'd2;
    localparam logic [2:0] REG_INTEGRAL_STEP = 3'd3;
    localparam logic [2:0] REG_RATE_DEADBAND = 3'd4;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_THETA,
        OP_THETA,
        OP_CAL,
        OP_MEAN_START,
        OP_SEED,
        OP_X,
        OP_DIFF,
        OP_FMUL_LO,
        OP_FMUL_HI,
        OP_FDIV_START,
        OP_F,
        OP_RUN,
        OP_SMUL_DEN,
        OP_SMUL_NUM,
        OP_SDIV_START,
        OP_INT,
        OP_CORR,
        OP_HMUL_LO,
        OP_HMUL_HI,
        OP_HEAD
    } op_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic calibrated;
        logic cal_full;
        logic den_zero;
        logic div_done;
        logic out_busy;
    } stat_t;

    // Clamp to the signed 51-bit range.
    function automatic logic signed [50:0] sat51(input logic signed [56:0] v);
        if (v > 57'(S51_MAX)) begin
            return S51_MAX;
        end else if (v < 57'(S51_MIN)) begin
            return S51_MIN;
        end
        return v[50:0];
    endfunction

    // Magnitude of a signed 51-bit value; the most negative value maps to 2^50.
    function automatic logic [50:0] abs51(input logic signed [50:0] v);
        logic signed [50:0] n;
        n = -v;
        return v[50] ? n : v;
    endfunction

endpackage

>>> hdl/gyro_heading_drift_compensator.sv
// ----------------------------------------------------------------------------
// Gyro heading drift compensator: top level
// Bias calibration, low-pass filter, sign-run integral correction and
// wrapped heading integration of a z-axis gyro rate.
//
//   Channel   Handshake          Payload
//   s_        s_valid/s_ready    s_gyro_rate_deg, s_sample_interval
//   m_        m_valid/m_ready    m_heading, m_corrected_rate
//   APB       psel/penable       paddr[5:3] register, pwdata/prdata 64 bits
//
// Calibration samples skip the divider; the seeding sample makes one pass
// for the sample mean. A tracking sample makes two passes through the
// shared one-bit-per-cycle divider (filter step, integral step); with a
// zero filter denominator the filter pass is skipped.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result stays in the output register; the next request is taken
// meanwhile and waits only at its own result step.
// ----------------------------------------------------------------------------
module gyro_heading_drift_compensator #(
    parameter int RUN_LIMIT = 1048575
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_gyro_rate_deg,
    input  logic [23:0]         s_sample_interval,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [35:0]  m_heading,
    output logic signed [50:0]  m_corrected_rate,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    logic [10:0] cal_samples_reg;
    logic [23:0] filter_tau_reg;
    logic [23:0] atten_c1_reg;
    logic [31:0] integral_step_reg;
    logic [39:0] rate_deadband_reg;
    logic        cfg_write;
    logic [2:0]  reg_index;

    ghdc_pkg::op_t   op;
    ghdc_pkg::stat_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[5:3];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg   <= 11'd1000;
            filter_tau_reg    <= 24'd167772;
            atten_c1_reg      <= 24'd16777;
            integral_step_reg <= 32'd14073749;
            rate_deadband_reg <= 40'd4398046511;
        end else if (cfg_write) begin
            unique case (reg_index)
                ghdc_pkg::REG_CAL_SAMPLES:   cal_samples_reg   <= pwdata[10:0];
                ghdc_pkg::REG_FILTER_TAU:    filter_tau_reg    <= pwdata[23:0];
                ghdc_pkg::REG_ATTEN_C1:      atten_c1_reg      <= pwdata[23:0];
                ghdc_pkg::REG_INTEGRAL_STEP: integral_step_reg <= pwdata[31:0];
                ghdc_pkg::REG_RATE_DEADBAND: rate_deadband_reg <= pwdata[39:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_index)
            ghdc_pkg::REG_CAL_SAMPLES:   prdata = {53'b0, cal_samples_reg};
            ghdc_pkg::REG_FILTER_TAU:    prdata = {40'b0, filter_tau_reg};
            ghdc_pkg::REG_ATTEN_C1:      prdata = {40'b0, atten_c1_reg};
            ghdc_pkg::REG_INTEGRAL_STEP: prdata = {32'b0, integral_step_reg};
            ghdc_pkg::REG_RATE_DEADBAND: prdata = {24'b0, rate_deadband_reg};
            default:                     prdata = '0;
        endcase
    end

    ghdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .op      (op)
    );

    ghdc_datapath #(
        .RUN_LIMIT (RUN_LIMIT)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .op                (op),
        .stat              (stat),
        .cal_samples       (cal_samples_reg),
        .filter_tau        (filter_tau_reg),
        .atten_c1          (atten_c1_reg),
        .integral_step     (integral_step_reg),
        .rate_deadband     (rate_deadband_reg),
        .s_gyro_rate_deg   (s_gyro_rate_deg),
        .s_sample_interval (s_sample_interval),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_heading         (m_heading),
        .m_corrected_rate  (m_corrected_rate)
    );

endmodule

>>> hdl/ghdc_divider.sv
// ----------------------------------------------------------------------------
// Gyro heading drift compensator: shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghdc_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ghdc_pkg::DVD_W-1:0]    dividend,
    input  logic [ghdc_pkg::DVS_W-1:0]    divisor,
    output logic [ghdc_pkg::DVD_W-1:0]    quotient,
    output logic                          done
);

    logic [ghdc_pkg::DVD_W-1:0]     quo_reg;
    logic [ghdc_pkg::DVS_W-1:0]     rem_reg;
    logic [ghdc_pkg::DVS_W-1:0]     dvs_reg;
    logic [ghdc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [ghdc_pkg::DVS_W:0]       trial;
    logic [ghdc_pkg::DVS_W:0]       trial_sub;
    logic                           fits;
    logic [ghdc_pkg::DVS_W-1:0]     rem_next;

    // Trial subtraction of the shifted remainder.
    always_comb begin
        trial     = {rem_reg, quo_reg[ghdc_pkg::DVD_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_next  = fits ? trial_sub[ghdc_pkg::DVS_W-1:0] : trial[ghdc_pkg::DVS_W-1:0];
    end

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ghdc_pkg::DIV_CNT_W'(ghdc_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Payload: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[ghdc_pkg::DVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    // The partial remainder stays below a nonzero divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && dvs_reg != '0) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // A new division never starts on top of a running one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Done comes only after the last bit, with the unit idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a finished run");

endmodule

>>> hdl/ghdc_datapath.sv
// ----------------------------------------------------------------------------
// Gyro heading drift compensator: datapath
// Holds all filter, controller and heading state, one shared multiplier,
// the shared divider and the result register. Each cycle executes the
// operation the controller issues.
// ----------------------------------------------------------------------------
module ghdc_datapath #(
    parameter int RUN_LIMIT = 1048575
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ghdc_pkg::op_t        op,
    output ghdc_pkg::stat_t      stat,
    input  logic [10:0]          cal_samples,
    input  logic [23:0]          filter_tau,
    input  logic [23:0]          atten_c1,
    input  logic [31:0]          integral_step,
    input  logic [39:0]          rate_deadband,
    input  logic signed [31:0]   s_gyro_rate_deg,
    input  logic [23:0]          s_sample_interval,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic signed [35:0]   m_heading,
    output logic signed [50:0]   m_corrected_rate
);

    localparam int RUN_W = $clog2(RUN_LIMIT + 1);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(RUN_LIMIT);

    // Payload registers of the item in flight.
    logic signed [31:0] g_reg;
    logic [23:0]        dt_reg;
    logic signed [60:0] prod_reg;
    logic [49:0]        part_reg;
    logic signed [50:0] theta_reg;
    logic signed [50:0] x_reg;
    logic [51:0]        absdiff_reg;
    logic               diff_neg_reg;
    logic signed [50:0] f_reg;
    logic [63:0]        den2_reg;
    logic signed [50:0] corr_reg;
    logic               in_db_reg;
    logic [23:0]        hlo_reg;
    logic signed [35:0] m_head_reg;
    logic signed [50:0] m_corr_reg;

    // Block state.
    logic [10:0]        cnt_reg;
    logic signed [63:0] rate_sum_reg;
    logic signed [50:0] peak_reg;
    logic signed [50:0] bias_reg;
    logic signed [50:0] pf_reg;
    logic signed [50:0] pc_reg;
    logic [RUN_W-1:0]   run_reg;
    logic signed [63:0] integ_reg;
    logic signed [35:0] head_reg;
    logic               calib_reg;
    logic               m_valid_reg;

    // Multiplier operands and divider interface.
    logic signed [32:0]            mul_a;
    logic signed [27:0]            mul_b;
    logic                          mul_en;
    logic                          div_start;
    logic [ghdc_pkg::DVD_W-1:0]    div_dividend;
    logic [ghdc_pkg::DVS_W-1:0]    div_divisor;
    logic [ghdc_pkg::DVD_W-1:0]    quo;
    logic                          div_done;

    // Combinational helpers.
    logic signed [60:0] neg_prod;
    logic [63:0]        sum_abs;
    logic signed [51:0] mean_q;
    logic signed [51:0] bias_sum;
    logic signed [50:0] bias_new;
    logic signed [50:0] x_seed;
    logic signed [50:0] x_new;
    logic signed [51:0] diff;
    logic [51:0]        diff_abs;
    logic [75:0]        filt_num;
    logic [63:0]        filt_den;
    logic               den_zero;
    logic signed [52:0] f_sum;
    logic               sign_match;
    logic [24:0]        one_c1;
    logic signed [65:0] step_ext;
    logic signed [65:0] integ_sum;
    logic signed [63:0] integ_new;
    logic signed [50:0] corr_new;
    logic signed [46:0] delta;
    logic signed [46:0] head_base;
    logic signed [46:0] head_sum;
    logic signed [35:0] head_new;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        one_c1 = ghdc_pkg::ONE_Q24 + {1'b0, atten_c1};
        case (op)
            ghdc_pkg::OP_MUL_THETA: begin
                mul_a = 33'(g_reg);
                mul_b = ghdc_pkg::DEG2RAD_Q32;
            end
            ghdc_pkg::OP_FMUL_LO: begin
                mul_a = {7'b0, absdiff_reg[25:0]};
                mul_b = {4'b0, dt_reg};
            end
            ghdc_pkg::OP_FMUL_HI: begin
                mul_a = {7'b0, absdiff_reg[51:26]};
                mul_b = {4'b0, dt_reg};
            end
            ghdc_pkg::OP_SMUL_DEN: begin
                mul_a = {9'b0, atten_c1};
                mul_b = 28'(run_reg);
            end
            ghdc_pkg::OP_SMUL_NUM: begin
                mul_a = {1'b0, integral_step};
                mul_b = {3'b0, one_c1};
            end
            ghdc_pkg::OP_HMUL_LO: begin
                mul_a = {1'b0, corr_reg[31:0]};
                mul_b = {4'b0, dt_reg};
            end
            ghdc_pkg::OP_HMUL_HI: begin
                mul_a = 33'(corr_reg[50:32]);
                mul_a = {{14{corr_reg[50]}}, corr_reg[50:32]};
                mul_b = {4'b0, dt_reg};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Divider requests: sample mean, filter step and attenuated integral step.
    always_comb begin
        filt_num     = {prod_reg[49:0], 26'b0} + {26'b0, part_reg};
        filt_den     = {40'b0, filter_tau} + {40'b0, dt_reg};
        den_zero     = (filter_tau == '0) && (dt_reg == '0);
        sum_abs      = rate_sum_reg[63] ? -rate_sum_reg : rate_sum_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (op)
            ghdc_pkg::OP_MEAN_START: begin
                div_start    = 1'b1;
                div_dividend = {12'b0, sum_abs};
                div_divisor  = {53'b0, cnt_reg};
            end
            ghdc_pkg::OP_FDIV_START: begin
                div_start    = !den_zero;
                div_dividend = filt_num;
                div_divisor  = filt_den;
            end
            ghdc_pkg::OP_SDIV_START: begin
                div_start    = 1'b1;
                div_dividend = {19'b0, prod_reg[56:0]};
                div_divisor  = den2_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    ghdc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quo),
        .done     (div_done)
    );

    // Arithmetic of the individual operations.
    always_comb begin
        // Negated rate, floor of the shift by eight.
        neg_prod = -prod_reg;

        // Seeding: bias from mean and peak, then the first history value.
        if (cnt_reg == '0) begin
            mean_q = '0;
        end else if (rate_sum_reg[63]) begin
            mean_q = -$signed(quo[51:0]);
        end else begin
            mean_q = $signed(quo[51:0]);
        end
        bias_sum = mean_q + 52'(peak_reg);
        bias_new = bias_sum[51:1];
        x_seed   = ghdc_pkg::sat51(57'(theta_reg) - 57'(bias_new));
        x_new    = ghdc_pkg::sat51(57'(theta_reg) - 57'(bias_reg));

        // Filter difference as sign and magnitude.
        diff     = 52'(x_reg) - 52'(pf_reg);
        diff_abs = diff[51] ? -diff : diff;

        // Filter output.
        if (den_zero) begin
            f_sum = 53'(pf_reg);
        end else if (diff_neg_reg) begin
            f_sum = 53'(pf_reg) - $signed({1'b0, quo[51:0]});
        end else begin
            f_sum = 53'(pf_reg) + $signed({1'b0, quo[51:0]});
        end

        // Equal sign of the new filter output and the previous correction.
        sign_match = (f_reg[50] == pc_reg[50]) && ((f_reg == '0) == (pc_reg == '0));

        // Integral correction, saturating at 64 bits.
        step_ext = $signed({33'b0, quo[32:0]});
        if (!pc_reg[50] && pc_reg != '0) begin
            integ_sum = 66'(integ_reg) - step_ext;
        end else if (pc_reg[50]) begin
            integ_sum = 66'(integ_reg) + step_ext;
        end else begin
            integ_sum = 66'(integ_reg);
        end
        if (integ_sum > ghdc_pkg::S64_MAX) begin
            integ_new = ghdc_pkg::S64_MAX[63:0];
        end else if (integ_sum < ghdc_pkg::S64_MIN) begin
            integ_new = ghdc_pkg::S64_MIN[63:0];
        end else begin
            integ_new = integ_sum[63:0];
        end

        corr_new = ghdc_pkg::sat51(57'(f_reg) + 57'(integ_reg >>> 8));

        // Heading: high partial product plus the carried low part.
        delta = in_db_reg ? '0 : (47'(prod_reg) + $signed({23'b0, hlo_reg}));
        if (47'(head_reg) >= ghdc_pkg::PI_Q) begin
            head_base = 47'(head_reg) - ghdc_pkg::TWO_PI_Q;
        end else if (47'(head_reg) <= -ghdc_pkg::PI_Q) begin
            head_base = 47'(head_reg) + ghdc_pkg::TWO_PI_Q;
        end else begin
            head_base = 47'(head_reg);
        end
        head_sum = head_base + delta;
        if (head_sum > ghdc_pkg::S36_MAX) begin
            head_new = ghdc_pkg::S36_MAX[35:0];
        end else if (head_sum < ghdc_pkg::S36_MIN) begin
            head_new = ghdc_pkg::S36_MIN[35:0];
        end else begin
            head_new = head_sum[35:0];
        end
    end

    // Block state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            rate_sum_reg <= '0;
            peak_reg     <= '0;
            bias_reg     <= '0;
            pf_reg       <= '0;
            pc_reg       <= '0;
            run_reg      <= '0;
            integ_reg    <= '0;
            head_reg     <= '0;
            calib_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (op == ghdc_pkg::OP_HEAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (op)
                ghdc_pkg::OP_CAL: begin
                    rate_sum_reg <= rate_sum_reg + 64'(theta_reg);
                    if (ghdc_pkg::abs51(theta_reg) > ghdc_pkg::abs51(peak_reg)) begin
                        peak_reg <= theta_reg;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ghdc_pkg::OP_SEED: begin
                    bias_reg  <= bias_new;
                    pf_reg    <= x_seed;
                    pc_reg    <= x_seed;
                    calib_reg <= 1'b1;
                end
                ghdc_pkg::OP_RUN: begin
                    if (!sign_match) begin
                        run_reg <= RUN_W'(1);
                    end else if (run_reg < RUN_MAX) begin
                        run_reg <= run_reg + 1'b1;
                    end
                end
                ghdc_pkg::OP_INT: begin
                    integ_reg <= integ_new;
                end
                ghdc_pkg::OP_CORR: begin
                    pf_reg <= f_reg;
                    pc_reg <= corr_new;
                end
                ghdc_pkg::OP_HEAD: begin
                    head_reg <= head_new;
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (op)
            ghdc_pkg::OP_LOAD: begin
                g_reg  <= s_gyro_rate_deg;
                dt_reg <= s_sample_interval;
            end
            ghdc_pkg::OP_THETA: begin
                theta_reg <= neg_prod[58:8];
            end
            ghdc_pkg::OP_X: begin
                x_reg <= x_new;
            end
            ghdc_pkg::OP_DIFF: begin
                absdiff_reg  <= diff_abs;
                diff_neg_reg <= diff[51];
            end
            ghdc_pkg::OP_FMUL_HI: begin
                part_reg <= prod_reg[49:0];
            end
            ghdc_pkg::OP_F: begin
                f_reg <= f_sum[50:0];
            end
            ghdc_pkg::OP_SMUL_NUM: begin
                den2_reg <= {16'b0, prod_reg[47:0]} + {39'b0, ghdc_pkg::ONE_Q24};
            end
            ghdc_pkg::OP_CORR: begin
                corr_reg <= corr_new;
            end
            ghdc_pkg::OP_HMUL_LO: begin
                in_db_reg <= (ghdc_pkg::abs51(corr_reg) < {11'b0, rate_deadband});
            end
            ghdc_pkg::OP_HMUL_HI: begin
                hlo_reg <= prod_reg[55:32];
            end
            ghdc_pkg::OP_HEAD: begin
                m_head_reg <= head_new;
                m_corr_reg <= corr_reg;
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller.
    always_comb begin
        stat.calibrated = calib_reg;
        stat.cal_full   = (cnt_reg >= cal_samples);
        stat.den_zero   = den_zero;
        stat.div_done   = div_done;
        stat.out_busy   = m_valid_reg && !m_ready;
    end

    assign m_valid          = m_valid_reg;
    assign m_heading        = m_head_reg;
    assign m_corrected_rate = m_corr_reg;

endmodule

>>> hdl/ghdc_ctrl.sv
// ----------------------------------------------------------------------------
// Gyro heading drift compensator: controller
// Sequences the datapath through calibration, seeding and the per-sample
// filter, integral and heading steps.
// ----------------------------------------------------------------------------
module ghdc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ghdc_pkg::stat_t  stat,
    output ghdc_pkg::op_t    op
);

    typedef enum logic [21:0] {
        S_IDLE      = 22'(1) << 0,
        S_MUL       = 22'(1) << 1,
        S_THETA     = 22'(1) << 2,
        S_CAL       = 22'(1) << 3,
        S_MEAN      = 22'(1) << 4,
        S_MEAN_WAIT = 22'(1) << 5,
        S_SEED      = 22'(1) << 6,
        S_X         = 22'(1) << 7,
        S_DIFF      = 22'(1) << 8,
        S_FMUL_LO   = 22'(1) << 9,
        S_FMUL_HI   = 22'(1) << 10,
        S_FDIV      = 22'(1) << 11,
        S_FDIV_WAIT = 22'(1) << 12,
        S_F         = 22'(1) << 13,
        S_RUN       = 22'(1) << 14,
        S_SMUL_DEN  = 22'(1) << 15,
        S_SMUL_NUM  = 22'(1) << 16,
        S_SDIV      = 22'(1) << 17,
        S_SDIV_WAIT = 22'(1) << 18,
        S_INT       = 22'(1) << 19,
        S_CORR      = 22'(1) << 20,
        S_HEAD      = 22'(1) << 21
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   hmul_lo_reg;
    logic   hmul_lo_next;

    // The high heading product is issued once, right after the low one.
    logic   hmul_hi_reg;

    // The heading products come ahead of the head step; two flags split the
    // head state into its low multiply, high multiply and result phases.
    always_comb begin
        state_next   = state_reg;
        hmul_lo_next = hmul_lo_reg;
        op           = ghdc_pkg::OP_NONE;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = ghdc_pkg::OP_LOAD;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                op         = ghdc_pkg::OP_MUL_THETA;
                state_next = S_THETA;
            end
            S_THETA: begin
                op = ghdc_pkg::OP_THETA;
                if (stat.calibrated) begin
                    state_next = S_X;
                end else if (stat.cal_full) begin
                    state_next = S_MEAN;
                end else begin
                    state_next = S_CAL;
                end
            end
            S_CAL: begin
                op         = ghdc_pkg::OP_CAL;
                state_next = S_IDLE;
            end
            S_MEAN: begin
                op         = ghdc_pkg::OP_MEAN_START;
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_SEED;
                end
            end
            S_SEED: begin
                op         = ghdc_pkg::OP_SEED;
                state_next = S_IDLE;
            end
            S_X: begin
                op         = ghdc_pkg::OP_X;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                op         = ghdc_pkg::OP_DIFF;
                state_next = S_FMUL_LO;
            end
            S_FMUL_LO: begin
                op         = ghdc_pkg::OP_FMUL_LO;
                state_next = S_FMUL_HI;
            end
            S_FMUL_HI: begin
                op         = ghdc_pkg::OP_FMUL_HI;
                state_next = S_FDIV;
            end
            S_FDIV: begin
                op         = ghdc_pkg::OP_FDIV_START;
                state_next = stat.den_zero ? S_F : S_FDIV_WAIT;
            end
            S_FDIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_F;
                end
            end
            S_F: begin
                op         = ghdc_pkg::OP_F;
                state_next = S_RUN;
            end
            S_RUN: begin
                op         = ghdc_pkg::OP_RUN;
                state_next = S_SMUL_DEN;
            end
            S_SMUL_DEN: begin
                op         = ghdc_pkg::OP_SMUL_DEN;
                state_next = S_SMUL_NUM;
            end
            S_SMUL_NUM: begin
                op         = ghdc_pkg::OP_SMUL_NUM;
                state_next = S_SDIV;
            end
            S_SDIV: begin
                op         = ghdc_pkg::OP_SDIV_START;
                state_next = S_SDIV_WAIT;
            end
            S_SDIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_INT;
                end
            end
            S_INT: begin
                op         = ghdc_pkg::OP_INT;
                state_next = S_CORR;
            end
            S_CORR: begin
                op           = ghdc_pkg::OP_CORR;
                hmul_lo_next = 1'b1;
                state_next   = S_HEAD;
            end
            S_HEAD: begin
                if (hmul_lo_reg) begin
                    op           = ghdc_pkg::OP_HMUL_LO;
                    hmul_lo_next = 1'b0;
                end else if (hmul_hi_reg) begin
                    op = ghdc_pkg::OP_HMUL_HI;
                end else if (stat.out_busy) begin
                    op = ghdc_pkg::OP_NONE;
                end else begin
                    op         = ghdc_pkg::OP_HEAD;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hmul_lo_reg <= 1'b0;
            hmul_hi_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hmul_lo_reg <= hmul_lo_next;
            hmul_hi_reg <= (op == ghdc_pkg::OP_HMUL_LO);
        end
    end

    // A new request is taken only when the controller is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE))
        else $error("input taken outside idle");

    // Every accepted sample starts with the rate multiply.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_MUL))
        else $error("accepted sample did not start");

    // The result step never overwrites a result still waiting downstream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ghdc_pkg::OP_HEAD) |-> !stat.out_busy)
        else $error("result written while output stalled");

    // The high product follows the low product directly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hmul_hi_reg |-> (state_reg == S_HEAD))
        else $error("heading product sequence broken");

endmodule
